FILE: src/hkv_pkg.sv
// shared constants, codes and the hash step function of the hashed key/value table
package hkv_pkg;

   localparam int BUCKETS  = 32;
   localparam int WAYS     = 4;
   localparam int SLOTS    = BUCKETS * WAYS;
   localparam int BUCKET_W = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
   localparam int FILL_W   = $clog2(WAYS + 1);
   localparam int TOT_W    = ($clog2(SLOTS + 1) > 8) ? $clog2(SLOTS + 1) : 8;
   localparam int ROW_W    = WAYS * 64;
   localparam int STEPS    = 6;
   localparam int STEP_W   = 3;

   localparam logic [31:0] HC0 = 32'h7ED55D16;
   localparam logic [31:0] HC1 = 32'hC761C23C;
   localparam logic [31:0] HC2 = 32'h165667B1;
   localparam logic [31:0] HC3 = 32'hD3A2646C;
   localparam logic [31:0] HC4 = 32'hFD7046C5;
   localparam logic [31:0] HC5 = 32'hB55A4F09;

   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(STEPS - 1);

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_LOOKUP = 1'b1;

   localparam logic [1:0] STAT_OK   = 2'd0;
   localparam logic [1:0] STAT_MISS = 2'd1;
   localparam logic [1:0] STAT_FULL = 2'd2;

   // one step of the integer mix, an add and/or xor chain selected by the step index
   function automatic logic [31:0] mix_step(input logic [31:0] a, input logic [STEP_W-1:0] step);
      logic [31:0] r;
      case (step)
         3'd0: r = (a + HC0) + (a << 12);
         3'd1: r = (a ^ HC1) ^ (a >> 19);
         3'd2: r = (a + HC2) + (a << 5);
         3'd3: r = (a + HC3) ^ (a << 9);
         3'd4: r = (a + HC4) + (a << 3);
         3'd5: r = (a ^ HC5) ^ (a >> 16);
         default: r = a;
      endcase
      return r;
   endfunction

endpackage

FILE: src/hashed_key_value_table_unit.sv
// hashed key/value table: top level with bucket memory and fill counts
// each request passes through key load, the six-step serial hash, the bucket-row read,
//    compare/write-back and a registered response strobe; busy stays high until the
//    response, so a new request is taken only after the last one is through
// reset: synchronous; clears all bucket fill counts and the entry total at once
// responses cannot be stalled: rsp_valid is high for exactly one cycle
module hashed_key_value_table_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_op,
   input  logic [31:0] req_key,
   input  logic [31:0] req_value,
   output logic        rsp_valid,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_found_value,
   output logic [7:0]  rsp_entries_held
);
   import hkv_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_HASH = 3'b010,
      ST_CMP  = 3'b100
   } state_type;

   state_type state_ff, state_in;

   logic        accept;
   logic        op_ff;
   logic [31:0] key_ff, value_ff;

   logic        hash_done;
   logic [31:0] hash;

   logic [BUCKET_W-1:0] bkt_ff, bkt_in;
   logic [FILL_W-1:0]   fill_ff [BUCKETS];
   logic [FILL_W-1:0]   cur_fill;
   logic [TOT_W-1:0]    total_ff, total_in;

   logic [ROW_W-1:0] row_mem [BUCKETS];
   logic [ROW_W-1:0] rd_row_ff;
   logic [ROW_W-1:0] wr_row;
   logic             wr_en;

   logic        found;
   logic [31:0] found_val;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  status_ff, status_in;
   logic [31:0] fval_ff, fval_in;

   assign accept = start && !busy;
   assign busy   = (state_ff != ST_IDLE);

   hkv_hash u_hash (
      .clock (clock),
      .reset (reset),
      .start (accept),
      .key   (req_key),
      .done  (hash_done),
      .hash  (hash)
   );

   assign cur_fill = fill_ff[bkt_ff];

   // earliest filled way with a matching key wins
   always_comb begin
      found     = 1'b0;
      found_val = '0;
      for (int w = WAYS - 1; w >= 0; w--) begin
         if ((FILL_W'(w) < cur_fill) && (rd_row_ff[w*64 +: 32] == key_ff)) begin
            found     = 1'b1;
            found_val = rd_row_ff[w*64+32 +: 32];
         end
      end
   end

   // merge the new pair into the next free way of the row
   always_comb begin
      wr_row = rd_row_ff;
      for (int w = 0; w < WAYS; w++) begin
         if (FILL_W'(w) == cur_fill) begin
            wr_row[w*64 +: 64] = {value_ff, key_ff};
         end
      end
   end

   assign wr_en = (state_ff == ST_CMP) && (op_ff == OP_INSERT) &&
                  (cur_fill < FILL_W'(WAYS));

   always_comb begin
      state_in     = state_ff;
      bkt_in       = bkt_ff;
      total_in     = total_ff;
      rsp_valid_in = 1'b0;
      status_in    = status_ff;
      fval_in      = fval_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_HASH;
            end
         end
         ST_HASH: begin
            if (hash_done) begin
               bkt_in   = hash[BUCKET_W-1:0];
               state_in = ST_CMP;
            end
         end
         ST_CMP: begin
            rsp_valid_in = 1'b1;
            fval_in      = '0;
            if (op_ff == OP_INSERT) begin
               if (wr_en) begin
                  status_in = STAT_OK;
                  total_in  = total_ff + 1'b1;
               end else begin
                  status_in = STAT_FULL;
               end
            end else if (found) begin
               status_in = STAT_OK;
               fval_in   = found_val;
            end else begin
               status_in = STAT_MISS;
            end
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         for (int b = 0; b < BUCKETS; b++) begin
            fill_ff[b] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
         if (wr_en) begin
            fill_ff[bkt_ff] <= cur_fill + 1'b1;
         end
      end
      if (accept) begin
         op_ff    <= req_op;
         key_ff   <= req_key;
         value_ff <= req_value;
      end
      bkt_ff    <= bkt_in;
      status_ff <= status_in;
      fval_ff   <= fval_in;
   end

   // bucket row memory, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         row_mem[bkt_ff] <= wr_row;
      end
      if (hash_done) begin
         rd_row_ff <= row_mem[hash[BUCKET_W-1:0]];
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_found_value  = fval_ff;
   assign rsp_entries_held = total_ff[7:0];

endmodule

FILE: src/hkv_hash.sv
// iterative key hash, one mix step per cycle
module hkv_hash (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] key,
   output logic        done,
   output logic [31:0] hash
);
   import hkv_pkg::*;

   logic              run_ff, run_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [31:0]       a_ff, a_in;

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      step_in = step_ff;
      a_in    = a_ff;
      if (start) begin
         run_in  = 1'b1;
         step_in = '0;
         a_in    = key;
      end else if (run_ff) begin
         a_in    = mix_step(a_ff, step_ff);
         step_in = step_ff + 1'b1;
         if (step_ff == LAST_STEP) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      a_ff <= a_in;
   end

   assign done = done_ff;
   assign hash = a_ff;

endmodule

FILE: test/tb.sv
// testbench for the hashed key/value table unit: random and directed requests against a predictor
`timescale 1ns / 1ps

module tb;
   import hkv_pkg::*;

   localparam int PERIOD      = 20;
   localparam int RESET_TICKS = 10;
   localparam int CYCLE_LIMIT = 200000;
   localparam int SETTLE      = 20;

   typedef struct {
      logic        op;
      logic [31:0] key;
      logic [31:0] value;
      int unsigned gap;
      bit          wait_drain;
   } table_request_type;

   typedef struct {
      logic [1:0]  status;
      logic [31:0] found_value;
      logic [7:0]  entries_held;
   } table_response_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic        req_op = OP_INSERT;
   logic [31:0] req_key = '0;
   logic [31:0] req_value = '0;
   logic        rsp_valid;
   logic [1:0]  rsp_status;
   logic [31:0] rsp_found_value;
   logic [7:0]  rsp_entries_held;

   table_request_type  request_queue[$];
   table_response_type response_queue[$];

   // predictor copy of the table
   logic [31:0] key_copy[SLOTS];
   logic [31:0] value_copy[SLOTS];
   int          bucket_count[BUCKETS];
   int          pair_count;

   int          fail_count = 0;
   int          cycle_count = 0;

   table_request_type staged;
   bit                staged_valid = 1'b0;
   int unsigned       gap_left = 0;

   hashed_key_value_table_unit dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_op           (req_op),
      .req_key          (req_key),
      .req_value        (req_value),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .rsp_found_value  (rsp_found_value),
      .rsp_entries_held (rsp_entries_held)
   );

   always #(PERIOD / 2) clock = ~clock;

   function automatic logic [31:0] jenkins_mix(input logic [31:0] k);
      logic [31:0] h;
      h = k;
      h = (h + HC0) + (h << 12);
      h = (h ^ HC1) ^ (h >> 19);
      h = (h + HC2) + (h << 5);
      h = (h + HC3) ^ (h << 9);
      h = (h + HC4) + (h << 3);
      h = (h ^ HC5) ^ (h >> 16);
      return h;
   endfunction

   function automatic int unsigned bucket_of(input logic [31:0] key);
      return int'(jenkins_mix(key) % 32'(BUCKETS));
   endfunction

   // updates the predictor table and gives the response the request should cause
   function automatic table_response_type apply_request(input logic op, input logic [31:0] key,
                                                         input logic [31:0] value);
      table_response_type r;
      int b;
      int fill;
      int base;
      b    = int'(bucket_of(key));
      fill = bucket_count[b];
      base = b * WAYS;
      r.status      = STAT_MISS;
      r.found_value = '0;
      if (op == OP_INSERT) begin
         if (fill >= WAYS) begin
            r.status = STAT_FULL;
         end else begin
            key_copy[base + fill]   = key;
            value_copy[base + fill] = value;
            bucket_count[b]         = fill + 1;
            pair_count++;
            r.status = STAT_OK;
         end
      end else begin
         // walk downwards so the earliest matching way wins
         for (int w = fill - 1; w >= 0; w--) begin
            if (key_copy[base + w] == key) begin
               r.found_value = value_copy[base + w];
               r.status      = STAT_OK;
            end
         end
      end
      r.entries_held = pair_count[7:0];
      return r;
   endfunction

   task automatic add_request(input logic op, input logic [31:0] key, input logic [31:0] value,
                              input bit eager, input bit drain);
      table_request_type t;
      t.op         = op;
      t.key        = key;
      t.value      = value;
      t.gap        = eager ? 0 : $urandom_range(3, 0);
      t.wait_drain = drain;
      request_queue.push_back(t);
   endtask

   // driver
   always @(posedge clock) begin : drive_proc
      bit fire;
      fire = start && !busy;
      if (reset) begin
         start     <= 1'b0;
         req_op    <= OP_INSERT;
         req_key   <= '0;
         req_value <= '0;
      end else begin
         if (fire)
            response_queue.push_back(apply_request(req_op, req_key, req_value));
         if (!staged_valid && request_queue.size() > 0) begin
            staged       = request_queue.pop_front();
            staged_valid = 1'b1;
            gap_left     = staged.gap;
         end
         if (start && !fire) begin
            // request held until taken
         end else if (staged_valid && gap_left == 0 &&
                      !(staged.wait_drain && (response_queue.size() != 0 || busy))) begin
            start        <= 1'b1;
            req_op       <= staged.op;
            req_key      <= staged.key;
            req_value    <= staged.value;
            staged_valid = 1'b0;
         end else begin
            start <= 1'b0;
            if (staged_valid && gap_left > 0 && !busy)
               gap_left--;
         end
      end
   end

   // monitor
   always @(posedge clock) begin : check_proc
      table_response_type want;
      if (!reset && rsp_valid) begin
         if (response_queue.size() == 0) begin
            $error("response with none pending: status %0d found_value %h entries_held %0d",
                   rsp_status, rsp_found_value, rsp_entries_held);
            fail_count++;
         end else begin
            want = response_queue.pop_front();
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_status);
               fail_count++;
            end
            if (rsp_found_value !== want.found_value) begin
               $error("found_value: expected %h, got %h", want.found_value, rsp_found_value);
               fail_count++;
            end
            if (rsp_entries_held !== want.entries_held) begin
               $error("entries_held: expected %0d, got %0d", want.entries_held,
                      rsp_entries_held);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin
      logic [31:0] crowd[$];
      logic [31:0] key_pool[$];
      logic [31:0] k;
      int unsigned target;
      bit          eager;
      bit          is_insert;

      for (int s = 0; s < SLOTS; s++) begin
         key_copy[s]   = '0;
         value_copy[s] = '0;
      end
      for (int b = 0; b < BUCKETS; b++)
         bucket_count[b] = 0;
      pair_count = 0;

      // directed: empty table, extreme keys and values, duplicates, a full bucket
      add_request(OP_LOOKUP, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0, 1'b0);
      add_request(OP_INSERT, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0);
      add_request(OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0);
      add_request(OP_LOOKUP, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 1'b0);
      add_request(OP_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 1'b0);
      add_request(OP_INSERT, 32'h0000_0000, 32'h1234_5678, 1'b0, 1'b0);
      add_request(OP_LOOKUP, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b1);
      add_request(OP_LOOKUP, 32'h0000_0001, 32'h0000_0000, 1'b0, 1'b0);

      target = bucket_of(32'h8000_0000);
      crowd.push_back(32'h8000_0000);
      for (k = 32'd1; crowd.size() < WAYS + 1; k++)
         if (bucket_of(k) == target)
            crowd.push_back(k);
      foreach (crowd[i])
         add_request(OP_INSERT, crowd[i], 32'h8000_0001 + i, 1'b1, 1'b0);
      add_request(OP_LOOKUP, crowd[WAYS], 32'hFFFF_FFFF, 1'b0, 1'b0);
      add_request(OP_LOOKUP, crowd[WAYS - 1], 32'h0000_0000, 1'b0, 1'b0);
      add_request(OP_LOOKUP, crowd[0], 32'h5555_5555, 1'b0, 1'b0);
      add_request(OP_INSERT, crowd[0], 32'hAAAA_AAAA, 1'b0, 1'b0);

      // random: about half the keys drawn from those already inserted, so lookups hit and buckets fill up
      eager = 1'b0;
      for (int i = 0; i < 850; i++) begin
         if (i % 50 == 0)
            eager = ($urandom_range(2, 0) == 0);
         is_insert = ($urandom_range(99, 0) < 45);
         if (key_pool.size() > 0 && $urandom_range(1, 0) == 1)
            k = key_pool[$urandom_range(key_pool.size() - 1, 0)];
         else
            k = $urandom;
         if (is_insert)
            key_pool.push_back(k);
         add_request(is_insert ? OP_INSERT : OP_LOOKUP, k, $urandom, eager, i % 200 == 0);
      end

      repeat (RESET_TICKS) @(posedge clock);
      reset <= 1'b0;

      while (request_queue.size() > 0 || staged_valid || start)
         @(posedge clock);
      while (response_queue.size() > 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);

      if (fail_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
